@@ rtl/core/lae_pkg.sv @@
// Package for the linear ADSR envelope generator.
// Holds the phase and mode codes, register indexes, reset values and shared types.
// It has no dependencies.
`timescale 1ns / 1ps

package lae_pkg;

   // Fixed-point format of the level: 1.0 equals 2^LEVEL_FRAC_BITS.
   localparam int LEVEL_FRAC_BITS_DEF = 24;

   // Widths of the fixed register and result fields.
   localparam int CSR_DATA_W  = 25;
   localparam int CSR_INDEX_W = 3;
   localparam int OUT_LEVEL_W = 25;

   typedef enum logic [2:0] {
      PH_OFF     = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      MODE_ADSR = 2'd0,
      MODE_ASR  = 2'd1,
      MODE_AR   = 2'd2
   } mode_type;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_STEP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_STEP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_STEP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LEVEL = 3'd4;

   // Request kinds.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_GATE = 1'b1;

   // Register values after reset.
   localparam logic [CSR_DATA_W-1:0] ATTACK_STEP_RST   = 25'd3495;
   localparam logic [CSR_DATA_W-1:0] DECAY_STEP_RST    = 25'd2621;
   localparam logic [CSR_DATA_W-1:0] RELEASE_STEP_RST  = 25'd612;
   localparam logic [CSR_DATA_W-1:0] SUSTAIN_LEVEL_RST = 25'd11744051;

   typedef struct packed {
      mode_type                mode;
      logic [CSR_DATA_W-1:0]   attack_step;
      logic [CSR_DATA_W-1:0]   decay_step;
      logic [CSR_DATA_W-1:0]   release_step;
      logic [CSR_DATA_W-1:0]   sustain_level;
   } cfg_type;

   typedef struct packed {
      logic [OUT_LEVEL_W-1:0] level;
      phase_type              phase;
      logic                   busy_res;
   } result_type;

endpackage

@@ rtl/core/lae_step.sv @@
// Next-state logic of the envelope: one tick or one gate change per item.
// Depends on lae_pkg for the phase and mode codes and the configuration struct.
`timescale 1ns / 1ps

module lae_step
   import lae_pkg::*;
#(
   parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
   input  cfg_type                    cfg,
   input  logic                       req_type,
   input  logic                       gate,
   input  logic [LEVEL_FRAC_BITS:0]   level,
   input  phase_type                  phase,
   input  logic                       gate_held,
   output logic [LEVEL_FRAC_BITS:0]   level_next,
   output phase_type                  phase_next,
   output logic                       gate_held_next
);

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam int SW = ((LW > CSR_DATA_W) ? LW : CSR_DATA_W) + 1;

   logic [SW-1:0] one;
   logic [SW-1:0] sustain_sat;
   logic [SW-1:0] lvl;
   logic [SW-1:0] attack_sum;
   logic [SW-1:0] attack_target;
   logic          attack_hit;
   logic [SW-1:0] fall_step;
   logic [SW-1:0] fall_floor;
   logic          fall_hit;
   logic [SW-1:0] fall_value;

   always_comb begin
      one         = SW'(1) << LEVEL_FRAC_BITS;
      sustain_sat = (SW'(cfg.sustain_level) > one) ? one : SW'(cfg.sustain_level);
      lvl         = SW'(level);

      attack_sum    = lvl + SW'(cfg.attack_step);
      attack_target = (cfg.mode == MODE_ASR) ? sustain_sat : one;
      attack_hit    = attack_sum >= attack_target;

      // Decay falls to the sustain level, release falls to zero.
      if (phase == PH_DECAY) begin
         fall_step  = SW'(cfg.decay_step);
         fall_floor = sustain_sat;
      end else begin
         fall_step  = SW'(cfg.release_step);
         fall_floor = '0;
      end
      fall_hit   = lvl <= (fall_floor + fall_step);
      fall_value = lvl - fall_step;
   end

   always_comb begin
      level_next     = level;
      phase_next     = phase;
      gate_held_next = gate_held;

      if (req_type == REQ_GATE) begin
         if (gate && !gate_held) begin
            phase_next = PH_ATTACK;
         end
         if (!gate && gate_held) begin
            phase_next = PH_RELEASE;
         end
         gate_held_next = (cfg.mode == MODE_AR) ? 1'b0 : gate;
      end else begin
         unique case (phase)
            PH_ATTACK: begin
               // Any defined mode climbs; the unused mode code holds.
               if (cfg.mode == MODE_ADSR || cfg.mode == MODE_ASR || cfg.mode == MODE_AR) begin
                  if (attack_hit) begin
                     level_next = LW'(attack_target);
                     unique case (cfg.mode)
                        MODE_ADSR: phase_next = PH_DECAY;
                        MODE_ASR:  phase_next = PH_SUSTAIN;
                        default:   phase_next = PH_RELEASE;
                     endcase
                  end else begin
                     level_next = LW'(attack_sum);
                  end
               end
            end
            PH_DECAY: begin
               if (cfg.mode == MODE_ADSR) begin
                  if (fall_hit) begin
                     level_next = LW'(fall_floor);
                     phase_next = PH_SUSTAIN;
                  end else begin
                     level_next = LW'(fall_value);
                  end
               end
            end
            PH_SUSTAIN: begin
               if ((cfg.mode == MODE_ADSR || cfg.mode == MODE_ASR) && !gate_held) begin
                  phase_next = PH_RELEASE;
               end
            end
            PH_RELEASE: begin
               if (cfg.mode == MODE_ADSR || cfg.mode == MODE_ASR || cfg.mode == MODE_AR) begin
                  if (fall_hit) begin
                     level_next = '0;
                     phase_next = PH_OFF;
                     if (cfg.mode == MODE_AR) begin
                        gate_held_next = 1'b0;
                     end
                  end else begin
                     level_next = LW'(fall_value);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ rtl/core/linear_adsr_envelope.sv @@
// Top level of the linear ADSR envelope generator.
// Depends on lae_pkg and instantiates lae_step for the per-item state update.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the request channel (req_valid, req_stall, req_type, req_gate)
// is either a sample tick (req_type low) or a gate change (req_type high, with
// the new gate on req_gate). Every request yields exactly one transfer on the
// response channel carrying the level, the phase and the busy flag after that
// request. The level is fixed point with full scale at 2^LEVEL_FRAC_BITS.
// The state update is a single add or subtract with a compare and clamp, so the
// response is registered without further pipelining, and the block takes one
// request per cycle for as long as the receiver keeps rsp_stall low.
// The response sits in an output register backed by one skid entry: when the
// receiver stalls, one further request is still taken into the skid entry, and
// req_stall rises only once both entries hold results. Results leave in order.
// Registers are written through csr_we, csr_index and csr_wdata, and should be
// changed only while no request is in flight. Writes to indexes past the list
// are ignored. Reset is synchronous: it empties both result entries, puts the
// envelope at level zero in the off phase with the gate released, and loads
// the default register values (ADSR mode and the default step sizes).
module linear_adsr_envelope
   import lae_pkg::*;
#(
   parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic                    req_gate,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OUT_LEVEL_W-1:0]  rsp_level,
   output logic [2:0]              rsp_phase,
   output logic                    rsp_busy_res,

   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam int XW = ((LW > OUT_LEVEL_W) ? LW : OUT_LEVEL_W) + 1;

   // Configuration registers.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Envelope state.
   logic [LW-1:0] level_ff;
   logic [LW-1:0] level_in;
   phase_type     phase_ff;
   phase_type     phase_in;
   logic          gate_held_ff;
   logic          gate_held_in;

   // Output register and skid entry.
   result_type    rsp_ff;
   result_type    rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   result_type    skid_ff;
   result_type    skid_in;
   logic          skid_valid_ff;
   logic          skid_valid_in;

   result_type    result_new;
   logic [XW-1:0] level_ext;
   logic          accept;
   logic          pop;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = rsp_valid_ff && !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:          cfg_in.mode          = mode_type'(csr_wdata[1:0]);
            CSR_ATTACK_STEP:   cfg_in.attack_step   = csr_wdata;
            CSR_DECAY_STEP:    cfg_in.decay_step    = csr_wdata;
            CSR_RELEASE_STEP:  cfg_in.release_step  = csr_wdata;
            CSR_SUSTAIN_LEVEL: cfg_in.sustain_level = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lae_step #(
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
   ) u_step (
      .cfg            (cfg_ff),
      .req_type       (req_type),
      .gate           (req_gate),
      .level          (level_ff),
      .phase          (phase_ff),
      .gate_held      (gate_held_ff),
      .level_next     (level_in),
      .phase_next     (phase_in),
      .gate_held_next (gate_held_in)
   );

   // The result field carries the low bits of the level.
   always_comb begin
      level_ext           = XW'(level_in);
      result_new.level    = level_ext[OUT_LEVEL_W-1:0];
      result_new.phase    = phase_in;
      result_new.busy_res = phase_in != PH_OFF;
   end

   // Two-entry result buffer: the skid entry fills only while the output
   // register is held by a stalled receiver.
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = result_new;
            rsp_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= MODE_ADSR;
         cfg_ff.attack_step   <= ATTACK_STEP_RST;
         cfg_ff.decay_step    <= DECAY_STEP_RST;
         cfg_ff.release_step  <= RELEASE_STEP_RST;
         cfg_ff.sustain_level <= SUSTAIN_LEVEL_RST;
         level_ff             <= '0;
         phase_ff             <= PH_OFF;
         gate_held_ff         <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         skid_valid_ff        <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            level_ff     <= level_in;
            phase_ff     <= phase_in;
            gate_held_ff <= gate_held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = rsp_ff.level;
   assign rsp_phase    = rsp_ff.phase;
   assign rsp_busy_res = rsp_ff.busy_res;

endmodule

@@ tb/tb_linear_adsr_envelope.sv @@
// Self-checking testbench for linear_adsr_envelope: directed and random ticks and gate changes,
// with random idling on both channels, checked against an in-bench envelope predictor.
// Depends on lae_pkg and the linear_adsr_envelope RTL.
`timescale 1ns / 1ps

module tb_linear_adsr_envelope;
   import lae_pkg::*;

   // Full scale of the level and a few bench constants.
   localparam logic [25:0] FULL_SCALE = 26'd1 << LEVEL_FRAC_BITS_DEF;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG = 3'd7;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 30;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic kind;
      logic gate_val;
   } envelope_req_type;

   // Clock, reset and every block input start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_type = 1'b0;
   logic req_gate = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic req_stall;
   logic rsp_valid;
   logic [OUT_LEVEL_W-1:0] rsp_level;
   logic [2:0] rsp_phase;
   logic rsp_busy_res;

   linear_adsr_envelope dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_gate     (req_gate),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_level    (rsp_level),
      .rsp_phase    (rsp_phase),
      .rsp_busy_res (rsp_busy_res),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // Shadow copy of the register file, starting at the reset values.
   logic [1:0] cur_mode = MODE_ADSR;
   logic [24:0] atk_step = ATTACK_STEP_RST;
   logic [24:0] dec_step = DECAY_STEP_RST;
   logic [24:0] rel_step = RELEASE_STEP_RST;
   logic [24:0] sus_level = SUSTAIN_LEVEL_RST;

   // Shadow envelope state: level, phase and the held gate.
   logic [25:0] env_level = '0;
   phase_type env_phase = PH_OFF;
   logic gate_held = 1'b0;

   // Requests waiting to be driven, and results the block still owes us.
   envelope_req_type envelope_req_q[$];
   result_type envelope_expect_q[$];
   envelope_req_type next_req;
   result_type want;

   int unsigned items_queued = 0;
   int unsigned items_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Idling controls. While calm is set neither side idles. The hold request
   // asks the stall process for one long hold-off of the result channel.
   logic calm = 1'b0;
   logic hold_request = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;

   // -------------------------------------------------------------------------
   // Envelope predictor
   // -------------------------------------------------------------------------

   // The sustain register may hold more than full scale; it saturates on use.
   function automatic logic [25:0] sat_sustain();
      return (27'(sus_level) > 27'(FULL_SCALE)) ? FULL_SCALE : 26'(sus_level);
   endfunction

   // Attack: climb by the attack step, and on reaching the target clamp there
   // and move on. A level already above the target is pulled down to it.
   task automatic rise_to(input logic [25:0] target, input phase_type nxt);
      logic [26:0] sum;
      sum = 27'(env_level) + 27'(atk_step);
      if (sum >= 27'(target)) begin
         env_level = target;
         env_phase = nxt;
      end else begin
         env_level = sum[25:0];
      end
   endtask

   // Decay or release: fall by one step, clamping at the floor. Returns 1 when
   // the floor was reached and the phase moved on.
   function automatic logic fall_to(input logic [24:0] step, input logic [25:0] floor_lvl,
                                    input phase_type nxt);
      if (27'(env_level) <= 27'(floor_lvl) + 27'(step)) begin
         env_level = floor_lvl;
         env_phase = nxt;
         return 1'b1;
      end
      env_level = env_level - 26'(step);
      return 1'b0;
   endfunction

   // Applies one accepted request to the shadow state and queues the result
   // the block must return for it.
   task automatic predict_envelope(input logic kind, input logic g);
      result_type r;
      if (kind == REQ_GATE) begin
         // A repeated gate value leaves the phase alone. AR mode never holds
         // the gate, so every rising gate there restarts the attack.
         if (g && !gate_held) begin
            env_phase = PH_ATTACK;
         end
         if (!g && gate_held) begin
            env_phase = PH_RELEASE;
         end
         gate_held = (cur_mode == MODE_AR) ? 1'b0 : g;
      end else begin
         // Phases that the current mode does not use simply hold on a tick,
         // and the unused mode code ignores ticks altogether.
         case (cur_mode)
            MODE_ADSR: begin
               case (env_phase)
                  PH_ATTACK: rise_to(FULL_SCALE, PH_DECAY);
                  PH_DECAY: void'(fall_to(dec_step, sat_sustain(), PH_SUSTAIN));
                  PH_SUSTAIN: if (!gate_held) env_phase = PH_RELEASE;
                  PH_RELEASE: void'(fall_to(rel_step, '0, PH_OFF));
                  default: ;
               endcase
            end
            MODE_ASR: begin
               case (env_phase)
                  PH_ATTACK: rise_to(sat_sustain(), PH_SUSTAIN);
                  PH_SUSTAIN: if (!gate_held) env_phase = PH_RELEASE;
                  PH_RELEASE: void'(fall_to(rel_step, '0, PH_OFF));
                  default: ;
               endcase
            end
            MODE_AR: begin
               case (env_phase)
                  PH_ATTACK: rise_to(FULL_SCALE, PH_RELEASE);
                  PH_RELEASE: begin
                     // Reaching zero in release also drops the held gate.
                     if (fall_to(rel_step, '0, PH_OFF)) gate_held = 1'b0;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      r.level = env_level[24:0];
      r.phase = env_phase;
      r.busy_res = (env_phase != PH_OFF);
      envelope_expect_q.push_back(r);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Idle lengths: mostly none, often short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [24:0] pick_step();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 8) return 25'd1;
      if (r < 14) return 25'(FULL_SCALE);
      if (r < 17) return '1;
      if (r < 22) return 25'($urandom_range(1, 4096));
      // Most steps take a note through a phase in a handful of ticks.
      return 25'(FULL_SCALE / $urandom_range(1, 24) + $urandom_range(0, 4095));
   endfunction

   function automatic logic [24:0] pick_sustain();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return 25'(FULL_SCALE);
      if (r < 28) return 25'($urandom_range(FULL_SCALE + 1, 2 ** 25 - 1));
      return 25'($urandom_range(0, FULL_SCALE));
   endfunction

   task automatic push_item(input logic kind, input logic g);
      envelope_req_type it;
      it.kind = kind;
      it.gate_val = g;
      envelope_req_q.push_back(it);
      items_queued++;
   endtask

   // Writes one register at the next rising edge and mirrors it in the shadow
   // copy. Only called while nothing is in flight, so the order is safe.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODE: cur_mode = val[1:0];
         CSR_ATTACK_STEP: atk_step = val;
         CSR_DECAY_STEP: dec_step = val;
         CSR_RELEASE_STEP: rel_step = val;
         CSR_SUSTAIN_LEVEL: sus_level = val;
         default: ;
      endcase
   endtask

   // Closes a group of writes and returns at a falling edge, where the
   // request queue may be filled without racing the driver.
   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   // Blocks until every queued request has been taken and answered.
   task automatic wait_idle();
      do @(negedge clock);
      while (envelope_req_q.size() != 0 || envelope_expect_q.size() != 0 || req_valid);
   endtask

   // One well-formed note: press, some ticks, release, some ticks. A repeated
   // press is slipped in now and then.
   task automatic queue_note();
      push_item(REQ_GATE, 1'b1);
      repeat ($urandom_range(0, 12)) push_item(REQ_TICK, 1'($urandom));
      if ($urandom_range(0, 5) == 0) push_item(REQ_GATE, 1'b1);
      push_item(REQ_GATE, 1'b0);
      repeat ($urandom_range(0, 12)) push_item(REQ_TICK, 1'($urandom));
   endtask

   task automatic randomize_settings();
      logic [1:0] m;
      int unsigned r;
      r = $urandom_range(0, 99);
      m = (r < 30) ? MODE_ADSR : (r < 55) ? MODE_ASR : (r < 85) ? MODE_AR : MODE_UNUSED;
      // Only the low two bits of a mode write count; the rest is sometimes noise.
      write_reg(CSR_MODE, ($urandom_range(0, 3) == 0) ? {23'($urandom), m} : 25'(m));
      // Some phases change only the mode, so a note can be caught in a phase
      // that the new mode does not use.
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_ATTACK_STEP, pick_step());
         write_reg(CSR_DECAY_STEP, pick_step());
         write_reg(CSR_RELEASE_STEP, pick_step());
         write_reg(CSR_SUSTAIN_LEVEL, pick_sustain());
      end
      if ($urandom_range(0, 4) == 0) write_reg(CSR_NO_REG, 25'($urandom));
      end_writes();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      error_count++;
      if (error_count <= 50)
         $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
   endtask

   // -------------------------------------------------------------------------
   // Request driver: presents queued requests with random gaps. A request is
   // held unchanged while the block stalls it; the prediction is made at the
   // edge where the transfer happens.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_envelope(req_type, req_gate);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (envelope_req_q.size() > 0) begin
               next_req = envelope_req_q.pop_front();
               req_valid <= 1'b1;
               req_type <= next_req.kind;
               req_gate <= next_req.gate_val;
               gap_left = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result stall: random stalls, none while calm, and one long hold-off on
   // request. The long hold-off is counted here, in cycles.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor: every result transfer is matched, field by field, with
   // the oldest outstanding prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (envelope_expect_q.size() == 0) begin
            report_mismatch("result with nothing outstanding, level", 32'(rsp_level), 32'd0);
         end else begin
            want = envelope_expect_q.pop_front();
            results_checked++;
            if (rsp_level !== want.level)
               report_mismatch("level", 32'(rsp_level), 32'(want.level));
            if (rsp_phase !== want.phase)
               report_mismatch("phase", 32'(rsp_phase), 32'(want.phase));
            if (rsp_busy_res !== want.busy_res)
               report_mismatch("busy", 32'(rsp_busy_res), 32'(want.busy_res));
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, envelope_expect_q.size());
         $display("tb_linear_adsr_envelope failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned phase_start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default settings: a tick while off, a repeated release, a press that
      // starts attack, a tick that carries a stray gate bit, a repeated press,
      // and a release out of attack.
      push_item(REQ_TICK, 1'b0);
      push_item(REQ_GATE, 1'b0);
      push_item(REQ_GATE, 1'b1);
      push_item(REQ_TICK, 1'b1);
      push_item(REQ_GATE, 1'b1);
      push_item(REQ_GATE, 1'b0);
      push_item(REQ_TICK, 1'b0);
      wait_idle();

      // Full-scale attack and release steps, a decay step of one and a sustain above
      // full scale: one tick per phase through attack, decay onto the saturated sustain,
      // a held sustain, and release down to off.
      write_reg(CSR_ATTACK_STEP, 25'(FULL_SCALE));
      write_reg(CSR_DECAY_STEP, 25'd1);
      write_reg(CSR_RELEASE_STEP, 25'(FULL_SCALE));
      write_reg(CSR_SUSTAIN_LEVEL, '1);
      end_writes();
      push_item(REQ_GATE, 1'b1);
      push_item(REQ_TICK, 1'b0);
      push_item(REQ_TICK, 1'b0);
      push_item(REQ_TICK, 1'b0);
      push_item(REQ_GATE, 1'b0);
      push_item(REQ_TICK, 1'b0);
      push_item(REQ_TICK, 1'b0);
      wait_idle();

      // Unused mode code with a zero attack step: ticks hold, gates still act.
      write_reg(CSR_MODE, 25'(MODE_UNUSED));
      write_reg(CSR_ATTACK_STEP, '0);
      end_writes();
      push_item(REQ_GATE, 1'b1);
      push_item(REQ_TICK, 1'b0);
      push_item(REQ_GATE, 1'b0);
      wait_idle();

      // AR mode, largest attack step and a zero release step: release never
      // ends, and a second press restarts attack since AR holds no gate.
      write_reg(CSR_MODE, 25'(MODE_AR));
      write_reg(CSR_ATTACK_STEP, '1);
      write_reg(CSR_RELEASE_STEP, '0);
      write_reg(CSR_SUSTAIN_LEVEL, '0);
      end_writes();
      push_item(REQ_GATE, 1'b1);
      push_item(REQ_TICK, 1'b0);
      push_item(REQ_TICK, 1'b0);
      push_item(REQ_GATE, 1'b1);
      push_item(REQ_TICK, 1'b0);
      wait_idle();

      // Into decay under ADSR, then ticks in AR and ASR, where decay is
      // foreign and must hold.
      write_reg(CSR_MODE, 25'(MODE_ADSR));
      write_reg(CSR_ATTACK_STEP, 25'(FULL_SCALE));
      write_reg(CSR_DECAY_STEP, '0);
      end_writes();
      push_item(REQ_GATE, 1'b1);
      push_item(REQ_TICK, 1'b0);
      wait_idle();
      write_reg(CSR_MODE, 25'(MODE_AR));
      end_writes();
      push_item(REQ_TICK, 1'b0);
      wait_idle();
      write_reg(CSR_MODE, 25'(MODE_ASR));
      end_writes();
      push_item(REQ_TICK, 1'b0);
      // Release, then a new attack from full scale down to a zero sustain.
      push_item(REQ_GATE, 1'b0);
      push_item(REQ_GATE, 1'b1);
      push_item(REQ_TICK, 1'b0);
      wait_idle();

      // Random phases: new settings each time, mostly whole notes with
      // random timing, the rest loose ticks and gate changes. Each phase ends
      // with the sender paused until all results are in.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         randomize_settings();
         calm = (p == 5);
         // In one phase the receiver holds off long enough for the block to
         // fill and push back on the request side.
         if (p == 2) hold_request = 1'b1;
         phase_start = items_queued;
         while (items_queued - phase_start < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 3) != 0)
               queue_note();
            else
               push_item(1'($urandom), 1'($urandom));
         end
         wait_idle();
         calm = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Drove %0d requests and checked %0d responses over %0d register settings,",
               items_accepted, results_checked, settings_used);
      $display("covering all modes, the unused mode code, and a long receiver hold-off.");
      if (error_count == 0 && envelope_expect_q.size() == 0) begin
         $display("tb_linear_adsr_envelope passed");
      end else begin
         $display("tb_linear_adsr_envelope failed");
      end
      $finish;
   end

endmodule
